[hdl/vrlv_pkg.sv]
// shared types, character codes and verdict codes for the variant record line validator
// no dependencies
package vrlv_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] FILTER_CHAR_RESET = 8'h50;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_FILTER_PASS_CHAR = 1'b0;

  typedef logic [2:0] field_t;
  localparam field_t FLD_CHROM  = 3'd0;
  localparam field_t FLD_REF    = 3'd3;
  localparam field_t FLD_ALT    = 3'd4;
  localparam field_t FLD_FILTER = 3'd6;
  localparam field_t FLD_LAST   = 3'd7;

  typedef logic [3:0] reason_t;
  localparam reason_t REASON_OK        = 4'd0;
  localparam reason_t REASON_COMMENT   = 4'd1;
  localparam reason_t REASON_CHROM     = 4'd2;
  localparam reason_t REASON_REF_BASE  = 4'd3;
  localparam reason_t REASON_REF_LONG  = 4'd4;
  localparam reason_t REASON_ALT_BASE  = 4'd5;
  localparam reason_t REASON_ALT_SEP   = 4'd6;
  localparam reason_t REASON_ALT_TRAIL = 4'd7;
  localparam reason_t REASON_FILTER    = 4'd8;
  localparam reason_t REASON_TRUNC     = 4'd9;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [31:0] line_number;
    reason_t     fail_reason;
    logic        line_valid;
  } verdict_t;

  function automatic logic is_base(input logic [7:0] c);
    is_base = (c == CH_A) || (c == CH_C) || (c == CH_G) || (c == CH_T);
  endfunction

endpackage

[hdl/variant_record_line_validator_core.sv]
// top level of the variant record line validator
// depends on vrlv_pkg, vrlv_cfg_regs, vrlv_line_check, vrlv_out_reg
//
// usage:
//   slave stream carries one byte of a tab-separated variant record line per
//   transfer, s_tlast marks the final byte of the line
//   master stream carries one verdict per line: valid flag, fail reason and
//   the saturating line number; bytes that do not end a line give no transfer
//   apb port holds filter_pass_char at address 0 (reset 'P')
// order: the last byte of a line passes the input register, then its verdict
//   the result register, before m_tvalid rises; a held result can keep that
//   byte waiting in the input register
// throughput: one byte per cycle while s_tready is high; the field check is a
//   single pass of logic between the input register and the result register
// reset: rst is synchronous; it clears line state, the line counter and both
//   valid flags, and returns filter_pass_char to 'P'
// stall: while m_tready is low a held verdict stays put; bytes keep flowing
//   until a further line end needs the result register, then s_tready drops
module variant_record_line_validator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] text_byte
  input  logic                                s_tlast,  // line_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] line_valid, [4:1] fail_reason, [36:5] line_number, rest zero
  output logic [vrlv_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vrlv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [vrlv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [vrlv_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import vrlv_pkg::*;

  logic [7:0] filter_pass_char;
  logic       res_valid;
  logic       res_ready;
  verdict_t   res;

  vrlv_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .filter_pass_char (filter_pass_char)
  );

  vrlv_line_check u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_byte          (s_tdata),
    .in_last          (s_tlast),
    .filter_pass_char (filter_pass_char),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  vrlv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[hdl/vrlv_cfg_regs.sv]
// configuration register bank behind the apb-style port
// depends on vrlv_pkg
module vrlv_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrlv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vrlv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vrlv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    filter_pass_char
);
  import vrlv_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[2] == REG_FILTER_PASS_CHAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_pass_char <= FILTER_CHAR_RESET;
    end else if (wr_en) begin
      filter_pass_char <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FILTER_PASS_CHAR) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, filter_pass_char};
    end
  end

endmodule

[hdl/vrlv_line_check.sv]
// input register, per-line field state and verdict logic
// depends on vrlv_pkg
module vrlv_line_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic [7:0]         filter_pass_char,
  output logic               res_valid,
  input  logic               res_ready,
  output vrlv_pkg::verdict_t res
);
  import vrlv_pkg::*;

  // input register
  logic       full;
  logic [7:0] byte_q;
  logic       last_q;
  logic       consume;

  // per-line state
  field_t      field_index, field_index_next;
  logic        byte_position;
  logic        alt_parity, alt_parity_next;
  logic        ref_seen_base, ref_seen_base_next;
  logic        last_was_comma, last_was_comma_next;
  reason_t     verdict_code, verdict_code_next;
  logic        filter_checked, filter_checked_next;
  logic [31:0] line_counter, line_counter_next;
  reason_t     final_code;

  assign consume  = full && (!last_q || res_ready);
  assign in_ready = !full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
  end

  // one byte of field checking
  always_comb begin
    field_index_next    = field_index;
    alt_parity_next     = alt_parity;
    ref_seen_base_next  = ref_seen_base;
    last_was_comma_next = last_was_comma;
    verdict_code_next   = verdict_code;
    filter_checked_next = filter_checked;
    if (verdict_code == REASON_OK) begin
      if (!byte_position && byte_q == CH_HASH) begin
        verdict_code_next = REASON_COMMENT;
      end else if (byte_q == CH_TAB) begin
        if (field_index == FLD_ALT && last_was_comma) begin
          verdict_code_next = REASON_ALT_TRAIL;
        end else if (field_index == FLD_FILTER && !filter_checked) begin
          verdict_code_next = REASON_FILTER;
        end else if (field_index != FLD_LAST) begin
          field_index_next = field_index + 3'd1;
        end
      end else begin
        case (field_index)
          FLD_CHROM: begin
            if (!(byte_q inside {[CH_ZERO:CH_NINE]})) begin
              verdict_code_next = REASON_CHROM;
            end
          end
          FLD_REF: begin
            if (ref_seen_base) begin
              verdict_code_next = REASON_REF_LONG;
            end else if (!is_base(byte_q)) begin
              verdict_code_next = REASON_REF_BASE;
            end else begin
              ref_seen_base_next = 1'b1;
            end
          end
          FLD_ALT: begin
            if (!alt_parity) begin
              if (is_base(byte_q)) begin
                alt_parity_next     = 1'b1;
                last_was_comma_next = 1'b0;
              end else begin
                verdict_code_next = REASON_ALT_BASE;
              end
            end else if (byte_q == CH_COMMA) begin
              alt_parity_next     = 1'b0;
              last_was_comma_next = 1'b1;
            end else begin
              verdict_code_next = REASON_ALT_SEP;
            end
          end
          FLD_FILTER: begin
            if (!filter_checked) begin
              if (byte_q != filter_pass_char) begin
                verdict_code_next = REASON_FILTER;
              end
              filter_checked_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // line-end judgement, truncation and empty filter caught here
  always_comb begin
    final_code = verdict_code_next;
    if (verdict_code_next == REASON_OK) begin
      if (field_index_next < FLD_FILTER) begin
        final_code = REASON_TRUNC;
      end else if (field_index_next == FLD_FILTER && !filter_checked_next) begin
        final_code = REASON_FILTER;
      end
    end
    line_counter_next = (line_counter == '1) ? line_counter : line_counter + 32'd1;
  end

  assign res_valid       = full && last_q;
  assign res.line_valid  = (final_code == REASON_OK);
  assign res.fail_reason = final_code;
  assign res.line_number = line_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index    <= FLD_CHROM;
      byte_position  <= 1'b0;
      alt_parity     <= 1'b0;
      ref_seen_base  <= 1'b0;
      last_was_comma <= 1'b0;
      verdict_code   <= REASON_OK;
      filter_checked <= 1'b0;
      line_counter   <= '0;
    end else if (consume) begin
      if (last_q) begin
        field_index    <= FLD_CHROM;
        byte_position  <= 1'b0;
        alt_parity     <= 1'b0;
        ref_seen_base  <= 1'b0;
        last_was_comma <= 1'b0;
        verdict_code   <= REASON_OK;
        filter_checked <= 1'b0;
        line_counter   <= line_counter_next;
      end else begin
        field_index    <= field_index_next;
        byte_position  <= 1'b1;
        alt_parity     <= alt_parity_next;
        ref_seen_base  <= ref_seen_base_next;
        last_was_comma <= last_was_comma_next;
        verdict_code   <= verdict_code_next;
        filter_checked <= filter_checked_next;
      end
    end
  end

endmodule

[hdl/vrlv_out_reg.sv]
// output register for verdicts, packs the master-side tdata
// depends on vrlv_pkg
module vrlv_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             res_valid,
  output logic                             res_ready,
  input  vrlv_pkg::verdict_t               res,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vrlv_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import vrlv_pkg::*;

  verdict_t held;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-$bits(verdict_t)){1'b0}}, held};

endmodule
